// ===== src/chte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types and constants for the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;
  localparam int unsigned NumNodes = 1024;
  localparam int unsigned IdxW = $clog2(NumNodes);
  localparam int unsigned LinkW = $clog2(NumNodes + 1);
  localparam logic [LinkW-1:0] NilLink = LinkW'(NumNodes);

  localparam logic [2:0] CmdLookup  = 3'd0;
  localparam logic [2:0] CmdInsert  = 3'd1;
  localparam logic [2:0] CmdDelete  = 3'd2;
  localparam logic [2:0] CmdUpdate  = 3'd3;
  localparam logic [2:0] CmdReplace = 3'd4;
  localparam logic [2:0] CmdErase   = 3'd5;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StMissing = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StDup     = 2'd3;
endpackage
`default_nettype wire

// ===== src/chained_hash_table_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Separate-chaining key/value table with a free-node stack.
// ----------------------------------------------------------------------------
// A command reads its bucket head, then walks the chain one node read at a time,
// decides, and rewrites a link when a node is added or removed; unused codes and
// an insert into a full table skip straight to the result. The engine takes one
// command at a time. Erase-all relinks the free list and clears bucket heads with
// a sweep over all NumNodes nodes, one node a cycle, and then gives its result.
// After reset the same sweep runs before the first command is taken.
module chained_hash_table_engine (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [71:0] s_axis_tdata,  // cmd[2:0], key[34:3], value[66:35]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [55:0] m_axis_tdata   // status[1:0], found_value[33:2],
                                     // node_slot[43:34], used_count[54:44]
);
  localparam int unsigned IdxW  = chte_pkg::IdxW;
  localparam int unsigned LinkW = chte_pkg::LinkW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_HEADW, S_NODE, S_NODEW, S_DECIDE, S_LINK, S_OUT
  } state_e;

  logic [31:0]      key_mem [chte_pkg::NumNodes];
  logic [31:0]      val_mem [chte_pkg::NumNodes];
  logic [LinkW-1:0] nxt_mem [chte_pkg::NumNodes];
  logic [LinkW-1:0] head_mem[chte_pkg::NumNodes];

  state_e           state_q;
  logic [2:0]       cmd_q;
  logic [31:0]      key_q, val_q;
  logic [IdxW-1:0]  bkt_q;
  logic [LinkW-1:0] cur_q, prev_q, free_q, hit_q, hnxt_q;
  logic [LinkW-1:0] steps_q;
  logic [LinkW-1:0] used_q;
  logic [IdxW-1:0]  clr_q;
  logic             found_q;
  logic [31:0]      rkey_q, rval_q;
  logic [LinkW-1:0] rnxt_q, rhead_q, rfree_q;
  logic [1:0]       st_q;
  logic [31:0]      fv_q;
  logic [IdxW-1:0]  slot_q;

  logic [16:0]      hsum;
  logic [IdxW-1:0]  bkt_d;
  assign hsum  = {1'b0, s_axis_tdata[34:19]} + {1'b0, s_axis_tdata[18:3]};
  assign bkt_d = IdxW'(hsum % 17'(chte_pkg::NumNodes));

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {1'b0, used_q, slot_q, fv_q, st_q};

  logic             we_key, we_val, we_nxt, we_head;
  logic [IdxW-1:0]  wa_node, wa_nxt, wa_head;
  logic [LinkW-1:0] wd_nxt, wd_head;
  logic [IdxW-1:0]  ra_node;
  logic             do_alloc;
  logic [LinkW-1:0] link_d;

  assign do_alloc = !found_q && (free_q != chte_pkg::NilLink)
                    && (cmd_q == chte_pkg::CmdInsert || cmd_q == chte_pkg::CmdReplace);
  assign link_d   = (cmd_q == chte_pkg::CmdDelete) ? hnxt_q : LinkW'(slot_q);

  always_ff @(posedge clk_i) begin
    if (we_key)  key_mem[wa_node]  <= key_q;
    if (we_val)  val_mem[wa_node]  <= val_q;
    if (we_nxt)  nxt_mem[wa_nxt]   <= wd_nxt;
    if (we_head) head_mem[wa_head] <= wd_head;
    rkey_q  <= key_mem[ra_node];
    rval_q  <= val_mem[ra_node];
    rnxt_q  <= nxt_mem[ra_node];
    rhead_q <= head_mem[bkt_q];
  end

  always_comb begin
    we_key = 1'b0; we_val = 1'b0; we_nxt = 1'b0; we_head = 1'b0;
    wa_node = free_q[IdxW-1:0]; wa_nxt = clr_q; wa_head = clr_q;
    wd_nxt = chte_pkg::NilLink; wd_head = chte_pkg::NilLink;
    ra_node = cur_q[IdxW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        we_nxt = 1'b1; we_head = 1'b1;
        wd_nxt = (clr_q == IdxW'(chte_pkg::NumNodes - 1)) ? chte_pkg::NilLink
               : LinkW'(clr_q) + LinkW'(1);
      end
      S_HEAD: ra_node = free_q[IdxW-1:0];
      S_DECIDE: begin
        if (do_alloc) begin
          we_key = 1'b1; we_val = 1'b1; we_nxt = 1'b1;
          wa_node = free_q[IdxW-1:0]; wa_nxt = free_q[IdxW-1:0];
        end else if (found_q && (cmd_q == chte_pkg::CmdUpdate
                                 || cmd_q == chte_pkg::CmdReplace)) begin
          we_val = 1'b1; wa_node = hit_q[IdxW-1:0];
        end else if (found_q && cmd_q == chte_pkg::CmdDelete) begin
          we_nxt = 1'b1; wa_nxt = hit_q[IdxW-1:0]; wd_nxt = free_q;
        end
      end
      S_LINK: begin
        if (prev_q < chte_pkg::NilLink) begin
          we_nxt = 1'b1; wa_nxt = prev_q[IdxW-1:0]; wd_nxt = link_d;
        end else begin
          we_head = 1'b1; wa_head = bkt_q; wd_head = link_d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      free_q  <= '0;
      used_q  <= '0;
      cmd_q   <= chte_pkg::CmdLookup;
      key_q   <= '0;
      val_q   <= '0;
      bkt_q   <= '0;
      cur_q   <= '0;
      prev_q  <= chte_pkg::NilLink;
      hit_q   <= '0;
      hnxt_q  <= '0;
      rfree_q <= '0;
      steps_q <= '0;
      found_q <= 1'b0;
      st_q    <= chte_pkg::StOk;
      fv_q    <= '0;
      slot_q  <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IdxW'(1);
          if (clr_q == IdxW'(chte_pkg::NumNodes - 1)) begin
            free_q <= '0; used_q <= '0;
            state_q <= (cmd_q == chte_pkg::CmdErase) ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q <= s_axis_tdata[2:0];
            key_q <= s_axis_tdata[34:3];
            val_q <= s_axis_tdata[66:35];
            bkt_q <= bkt_d;
            st_q <= chte_pkg::StOk; fv_q <= '0; slot_q <= '0;
            prev_q <= chte_pkg::NilLink; steps_q <= '0; found_q <= 1'b0;
            if (s_axis_tdata[2:0] == chte_pkg::CmdErase) begin
              clr_q <= '0; state_q <= S_CLEAR;
            end else if (s_axis_tdata[2:0] > chte_pkg::CmdErase) begin
              state_q <= S_OUT;
            end else if (s_axis_tdata[2:0] == chte_pkg::CmdInsert
                         && free_q == chte_pkg::NilLink) begin
              st_q <= chte_pkg::StFull; state_q <= S_OUT;
            end else begin
              state_q <= S_HEAD;
            end
          end
        end
        S_HEAD: state_q <= S_HEADW;
        S_HEADW: begin
          rfree_q <= rnxt_q;
          cur_q <= rhead_q;
          state_q <= (rhead_q < chte_pkg::NilLink) ? S_NODE : S_DECIDE;
        end
        S_NODE: state_q <= S_NODEW;
        S_NODEW: begin
          if (rkey_q == key_q) begin
            found_q <= 1'b1; hit_q <= cur_q; fv_q <= rval_q;
            hnxt_q <= rnxt_q; state_q <= S_DECIDE;
          end else begin
            prev_q <= cur_q; cur_q <= rnxt_q; steps_q <= steps_q + LinkW'(1);
            state_q <= (rnxt_q < chte_pkg::NilLink
                        && steps_q + LinkW'(1) < chte_pkg::NilLink)
                       ? S_NODE : S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!(found_q && (cmd_q == chte_pkg::CmdLookup
                            || cmd_q == chte_pkg::CmdDelete))) begin
            fv_q <= '0;
          end
          if (do_alloc) begin
            slot_q <= free_q[IdxW-1:0];
            free_q <= rfree_q;
            used_q <= used_q + LinkW'(1);
            state_q <= S_LINK;
          end else if (found_q && cmd_q == chte_pkg::CmdDelete) begin
            slot_q <= hit_q[IdxW-1:0];
            free_q <= hit_q;
            if (used_q != '0) used_q <= used_q - LinkW'(1);
            state_q <= S_LINK;
          end else begin
            state_q <= S_OUT;
            if (found_q) begin
              slot_q <= hit_q[IdxW-1:0];
              if (cmd_q == chte_pkg::CmdInsert) st_q <= chte_pkg::StDup;
            end else if (cmd_q == chte_pkg::CmdReplace) begin
              st_q <= chte_pkg::StFull;
            end else begin
              st_q <= chte_pkg::StMissing;
            end
          end
        end
        S_LINK: state_q <= S_OUT;
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/chained_hash_table_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine_tb
// Drives table commands over the input stream with random gaps, predicts each
// response with a behavioral copy of the table, and compares every response
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_tb;
  localparam int unsigned CycleLimit = 10000000;

  typedef struct packed {
    logic [10:0] used_count;
    logic [9:0]  node_slot;
    logic [31:0] found_value;
    logic [1:0]  status;
  } resp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;

  chained_hash_table_engine dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  logic [31:0]                tbl_key   [chte_pkg::NumNodes];
  logic [31:0]                tbl_value [chte_pkg::NumNodes];
  logic [chte_pkg::LinkW-1:0] tbl_next  [chte_pkg::NumNodes];
  logic [chte_pkg::LinkW-1:0] tbl_head  [chte_pkg::NumNodes];
  logic [chte_pkg::LinkW-1:0] tbl_free;
  logic [10:0]                tbl_used;

  resp_t       expected_resps[$];
  logic [31:0] live_keys[$];
  int          err_count;
  int unsigned cycle_count;
  bit          calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void table_clear();
    for (int i = 0; i < chte_pkg::NumNodes; i++) begin
      tbl_next[i] = chte_pkg::LinkW'(i + 1);
      tbl_head[i] = chte_pkg::NilLink;
    end
    tbl_free = '0;
    tbl_used = '0;
  endfunction

  function automatic logic [chte_pkg::LinkW-1:0] bucket_index(logic [31:0] key);
    logic [16:0] s;
    s = {1'b0, key[31:16]} + {1'b0, key[15:0]};
    return chte_pkg::LinkW'(s % chte_pkg::NumNodes);
  endfunction

  // Return the match or NilLink; prev gets the predecessor or chain tail.
  function automatic logic [chte_pkg::LinkW-1:0] chain_find(
      logic [chte_pkg::LinkW-1:0] b, logic [31:0] key,
      output logic [chte_pkg::LinkW-1:0] prev);
    logic [chte_pkg::LinkW-1:0] cur;
    int steps;
    cur = tbl_head[b];
    prev = chte_pkg::NilLink;
    steps = 0;
    while (cur < chte_pkg::NilLink && steps < chte_pkg::NumNodes) begin
      if (tbl_key[cur] == key) return cur;
      prev = cur;
      cur = tbl_next[cur];
      steps++;
    end
    return chte_pkg::NilLink;
  endfunction

  function automatic logic [chte_pkg::LinkW-1:0] node_alloc(
      logic [chte_pkg::LinkW-1:0] b, logic [chte_pkg::LinkW-1:0] tail,
      logic [31:0] key, logic [31:0] val);
    logic [chte_pkg::LinkW-1:0] n;
    n = tbl_free;
    tbl_free = tbl_next[n];
    tbl_used++;
    tbl_key[n] = key;
    tbl_value[n] = val;
    tbl_next[n] = chte_pkg::NilLink;
    if (tail < chte_pkg::NilLink) tbl_next[tail] = n;
    else tbl_head[b] = n;
    return n;
  endfunction

  function automatic resp_t table_apply(logic [2:0] cmd, logic [31:0] key, logic [31:0] val);
    resp_t r;
    logic [chte_pkg::LinkW-1:0] b, prev, hit, slot;
    r = '0;
    slot = '0;
    b = bucket_index(key);
    case (cmd)
      chte_pkg::CmdLookup: begin
        hit = chain_find(b, key, prev);
        if (hit < chte_pkg::NilLink) begin
          r.found_value = tbl_value[hit];
          slot = hit;
        end else r.status = chte_pkg::StMissing;
      end
      chte_pkg::CmdInsert: begin
        if (tbl_free >= chte_pkg::NilLink) r.status = chte_pkg::StFull;
        else begin
          hit = chain_find(b, key, prev);
          if (hit < chte_pkg::NilLink) begin
            r.status = chte_pkg::StDup;
            slot = hit;
          end else slot = node_alloc(b, prev, key, val);
        end
      end
      chte_pkg::CmdDelete: begin
        hit = chain_find(b, key, prev);
        if (hit >= chte_pkg::NilLink) r.status = chte_pkg::StMissing;
        else begin
          if (prev < chte_pkg::NilLink) tbl_next[prev] = tbl_next[hit];
          else tbl_head[b] = tbl_next[hit];
          r.found_value = tbl_value[hit];
          slot = hit;
          tbl_next[hit] = tbl_free;
          tbl_free = hit;
          if (tbl_used > 0) tbl_used--;
        end
      end
      chte_pkg::CmdUpdate: begin
        hit = chain_find(b, key, prev);
        if (hit < chte_pkg::NilLink) begin
          tbl_value[hit] = val;
          slot = hit;
        end else r.status = chte_pkg::StMissing;
      end
      chte_pkg::CmdReplace: begin
        hit = chain_find(b, key, prev);
        if (hit < chte_pkg::NilLink) begin
          tbl_value[hit] = val;
          slot = hit;
        end else if (tbl_free >= chte_pkg::NilLink) r.status = chte_pkg::StFull;
        else slot = node_alloc(b, prev, key, val);
      end
      chte_pkg::CmdErase: table_clear();
      default: ;
    endcase
    r.node_slot = slot[chte_pkg::IdxW-1:0];
    r.used_count = tbl_used;
    return r;
  endfunction

  task automatic send_cmd(logic [2:0] cmd, logic [31:0] key, logic [31:0] val);
    if (!calm) begin
      while ($urandom_range(99) < 27) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, val, key, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_resps.push_back(table_apply(cmd, key, val));
    if (cmd == chte_pkg::CmdErase) live_keys.delete();
    else if (cmd == chte_pkg::CmdInsert || cmd == chte_pkg::CmdReplace)
      live_keys.push_back(key);
  endtask

  task automatic drain_resps();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_resps.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    if (live_keys.size() != 0 && $urandom_range(3) != 0)
      return live_keys[$urandom_range(live_keys.size() - 1)];
    if ($urandom_range(1)) return {16'($urandom_range(3)), 16'($urandom_range(255))};
    return $urandom;
  endfunction

  always @(posedge clk_i) begin
    resp_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[54:0];
        if (expected_resps.size() == 0) begin
          $display("%0t unexpected response %h", $time, got);
          err_count++;
        end else begin
          want = expected_resps.pop_front();
          if (got.status !== want.status) begin
            $display("%0t status exp %0d got %0d", $time, want.status, got.status);
            err_count++;
          end
          if (got.found_value !== want.found_value) begin
            $display("%0t found_value exp %h got %h", $time, want.found_value,
                     got.found_value);
            err_count++;
          end
          if (got.node_slot !== want.node_slot) begin
            $display("%0t node_slot exp %0d got %0d", $time, want.node_slot, got.node_slot);
            err_count++;
          end
          if (got.used_count !== want.used_count) begin
            $display("%0t used_count exp %0d got %0d", $time, want.used_count,
                     got.used_count);
            err_count++;
          end
        end
      end
      m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
    end
  end

  task automatic test_directed();
    send_cmd(chte_pkg::CmdLookup, 32'h0, 32'h0);
    send_cmd(chte_pkg::CmdInsert, 32'h0, 32'h7FFF_FFFF);
    send_cmd(chte_pkg::CmdInsert, 32'hFFFF_FFFF, 32'h8000_0000);
    send_cmd(chte_pkg::CmdInsert, 32'h0001_0000, 32'hFFFF_FFFF); // same bucket as key 1
    send_cmd(chte_pkg::CmdInsert, 32'h0000_0001, 32'h1234_5678);
    send_cmd(chte_pkg::CmdInsert, 32'h0000_0001, 32'h5555_5555);
    send_cmd(chte_pkg::CmdLookup, 32'h0000_0001, 32'h0);
    send_cmd(chte_pkg::CmdLookup, 32'hFFFF_FFFF, 32'h0);
    send_cmd(chte_pkg::CmdUpdate, 32'h0001_0000, 32'hAAAA_AAAA);
    send_cmd(chte_pkg::CmdUpdate, 32'h0000_0002, 32'h1);
    send_cmd(chte_pkg::CmdReplace, 32'h0000_0001, 32'h0);
    send_cmd(chte_pkg::CmdReplace, 32'h0000_0400, 32'h0F0F_0F0F);
    send_cmd(chte_pkg::CmdDelete, 32'h0001_0000, 32'h0);
    send_cmd(chte_pkg::CmdDelete, 32'h0001_0000, 32'h0);
    send_cmd(chte_pkg::CmdLookup, 32'h0000_0001, 32'h0);
    send_cmd(chte_pkg::CmdInsert, 32'h0002_0000, 32'h3);
    send_cmd(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(3'd7, 32'h0, 32'h0);
    send_cmd(chte_pkg::CmdErase, 32'hDEAD_BEEF, 32'h0);
    send_cmd(chte_pkg::CmdLookup, 32'h0, 32'h0);
    send_cmd(chte_pkg::CmdInsert, 32'h0, 32'h1);
  endtask

  // Fill to capacity, then exercise full-table insert and replace paths.
  task automatic test_full_table();
    send_cmd(chte_pkg::CmdErase, 32'h0, 32'h0);
    for (int i = 0; i < chte_pkg::NumNodes; i++)
      send_cmd(chte_pkg::CmdInsert, {16'($urandom_range(7)), 16'(i * 3)}, $urandom);
    send_cmd(chte_pkg::CmdInsert, live_keys[0], 32'h1);
    send_cmd(chte_pkg::CmdInsert, 32'hFFFF_0000, 32'h1);
    send_cmd(chte_pkg::CmdReplace, 32'hFFFF_0000, 32'h2);
    send_cmd(chte_pkg::CmdReplace, live_keys[5], 32'h2);
    send_cmd(chte_pkg::CmdDelete, live_keys[5], 32'h0);
    send_cmd(chte_pkg::CmdInsert, 32'hFFFF_0000, 32'h3);
    drain_resps();
    send_cmd(chte_pkg::CmdErase, 32'h0, 32'h0);
  endtask

  task automatic test_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 3 + 60);
      pick = $urandom_range(99);
      if (pick < 1) send_cmd(chte_pkg::CmdErase, $urandom, $urandom);
      else if (pick < 3) send_cmd(3'($urandom_range(7, 6)), $urandom, $urandom);
      else send_cmd(3'($urandom_range(4)), pick_key(), $urandom);
    end
    calm = 1'b0;
  endtask

  initial begin
    err_count = 0;
    cycle_count = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    table_clear();
    for (int i = 0; i < chte_pkg::NumNodes; i++) begin
      tbl_key[i] = '0;
      tbl_value[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_table();
    test_random(250);
    drain_resps();
    test_random(200);
    drain_resps();
    repeat (50) @(posedge clk_i);
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
